// ===== design/utf8_to_utf16_transcoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// utf8 to utf16 transcoder assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH

// same-cycle implication
`define UTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg
// types and constants shared by the utf8 to utf16 transcoder
// ----------------------------------------------------------------------------
`default_nettype none

package utt_pkg;

	// input word: one utf-8 byte plus end-of-string flag
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_word_t;

	// output word: one utf-16 unit
	typedef struct packed {
		logic [15:0] out_unit;
		logic        last_of_run;
		logic [15:0] units_so_far;
	} out_word_t;

	// per-string decoder state
	typedef struct packed {
		logic [1:0]  bytes_pending;
		logic [20:0] code_accum;
		logic [15:0] units_written;
		logic        halted;
	} dec_state_t;

	// units produced by one byte
	typedef struct packed {
		logic [1:0] count;
		out_word_t  word0;
		out_word_t  word1;
	} dec_result_t;

	// output queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);
	localparam logic [FIFO_LW-1:0] FIFO_ROOM_LIMIT = FIFO_LW'(FIFO_DEPTH - 2);
	localparam logic [FIFO_LW-1:0] FIFO_FULL_LEVEL = FIFO_LW'(FIFO_DEPTH);

	// output queue status
	typedef struct packed {
		logic [FIFO_LW-1:0] level;
		logic               room2;
	} fifo_stat_t;

	// lead byte tags
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	// code point ranges
	localparam logic [20:0] CP_BMP_LOW_END    = 21'h00D7FF;
	localparam logic [20:0] CP_BMP_HIGH_START = 21'h00E000;
	localparam logic [20:0] CP_BMP_END        = 21'h00FFFF;
	localparam logic [20:0] CP_SUPP_START     = 21'h010000;
	localparam logic [20:0] CP_MAX            = 21'h10FFFF;

	// surrogate bases
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;

	localparam logic [15:0] CAP_RESET = 16'hFFFF;

endpackage

`default_nettype wire

// ===== design/utt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// utt_out_fifo
// small output queue, takes up to two units per cycle, gives one
// ----------------------------------------------------------------------------
`default_nettype none

module utt_out_fifo import utt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  push_count,
	input  wire out_word_t   push_word0,
	input  wire out_word_t   push_word1,
	input  wire logic        pop,
	output logic             head_valid,
	output out_word_t        head_word,
	output fifo_stat_t       stat
);

	out_word_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_LW-1:0] level_q;
	logic [FIFO_LW-1:0] level_after_pop;
	logic [FIFO_AW-1:0] wr_ptr_next1;

	assign wr_ptr_next1    = wr_ptr_q + FIFO_AW'(1);
	assign level_after_pop = level_q - FIFO_LW'(pop);

	assign head_valid  = (level_q != '0);
	assign head_word   = mem_q[rd_ptr_q];
	assign stat.level  = level_q;
	assign stat.room2  = (level_after_pop <= FIFO_ROOM_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_count);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			level_q  <= level_after_pop + FIFO_LW'(push_count);
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push_word0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr_next1] <= push_word1;
		end
	end

endmodule

`default_nettype wire

// ===== design/utt_decode.sv =====
// ----------------------------------------------------------------------------
// utt_decode
// one byte of utf-8 against current state: next state and utf-16 units
// ----------------------------------------------------------------------------
`default_nettype none

module utt_decode import utt_pkg::*; (
	input  wire in_word_t    word,
	input  wire dec_state_t  state,
	input  wire logic [15:0] capacity,
	output dec_state_t       state_next,
	output dec_result_t      result
);

	logic        emit_req;
	logic [20:0] emit_cp;
	logic [20:0] acc_shifted;
	logic [20:0] supp_off;
	logic        is_one;
	logic        is_two;
	logic [1:0]  need;
	logic        fits;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;
	logic [7:0]  b;

	assign b           = word.in_byte;
	assign acc_shifted = {state.code_accum[14:0], b[5:0]};

	// classify the finished code point
	assign is_one   = (emit_cp <= CP_BMP_LOW_END) ||
	                  ((emit_cp >= CP_BMP_HIGH_START) && (emit_cp <= CP_BMP_END));
	assign is_two   = (emit_cp >= CP_SUPP_START) && (emit_cp <= CP_MAX);
	assign need     = is_two ? 2'd2 : (is_one ? 2'd1 : 2'd0);
	assign fits     = ({1'b0, state.units_written} + 17'(need)) <= {1'b0, capacity};
	assign supp_off = emit_cp - CP_SUPP_START;
	assign hi_unit  = HI_SURR_BASE + 16'(supp_off[19:10]);
	assign lo_unit  = LO_SURR_BASE + 16'(supp_off[9:0]);

	always_comb begin
		state_next = state;
		emit_req   = 1'b0;
		emit_cp    = '0;
		if (!state.halted) begin
			priority if (state.bytes_pending != 2'd0) begin
				state_next.code_accum    = acc_shifted;
				state_next.bytes_pending = state.bytes_pending - 2'd1;
				emit_req                 = (state.bytes_pending == 2'd1);
				emit_cp                  = acc_shifted;
			end else if (!b[7]) begin
				emit_req = 1'b1;
				emit_cp  = 21'(b);
			end else if (b[7:5] == LEAD2_TAG) begin
				state_next.code_accum    = 21'(b[4:0]);
				state_next.bytes_pending = 2'd1;
			end else if (b[7:4] == LEAD3_TAG) begin
				state_next.code_accum    = 21'(b[3:0]);
				state_next.bytes_pending = 2'd2;
			end else if (b[7:3] == LEAD4_TAG) begin
				state_next.code_accum    = 21'(b[2:0]);
				state_next.bytes_pending = 2'd3;
			end else begin
				// invalid lead byte gives u+0000 unless it ends the string
				emit_req = !word.end_of_string;
				emit_cp  = '0;
			end
		end

		result.count = 2'd0;
		if (emit_req && (need != 2'd0)) begin
			if (fits) begin
				result.count             = need;
				state_next.units_written = state.units_written + 16'(need);
			end else begin
				state_next.halted = 1'b1;
			end
		end

		if (word.end_of_string) begin
			state_next = '0;
		end

		result.word0.out_unit     = is_two ? hi_unit : emit_cp[15:0];
		result.word0.last_of_run  = !is_two;
		result.word0.units_so_far = state.units_written + 16'd1;
		result.word1.out_unit     = lo_unit;
		result.word1.last_of_run  = 1'b1;
		result.word1.units_so_far = state.units_written + 16'd2;
	end

endmodule

`default_nettype wire

// ===== design/utf8_to_utf16_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// streaming utf-8 to utf-16 transcoder with a per-string unit capacity
//
//   channel  | direction | handshake             | word
//   ---------+-----------+-----------------------+--------------------------
//   in       | sink      | in_valid / in_stall   | in_word_t  (byte, eos)
//   out      | source    | out_valid / out_stall | out_word_t (unit, last, count)
//   cfg      | sink      | cfg_valid / cfg_ready | out_capacity, 16 bits
//
// one byte accepted per cycle while in_stall is low; the first unit of a byte is
// offered only after it has passed through both registers
// (input register, then output queue)
// a surrogate pair is two units but comes from four bytes, so with
// the output never stalled the queue stays at two words or less and the input
// never stalls
// in_stall rises only while the input register holds a byte that the output
// queue cannot take two more units for
// reset clears string state, queue and input register; capacity resets to 65535
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_core import utt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_word_t    in_data,
	// output unit channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_word_t        out_data,
	// capacity register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	`include "utf8_to_utf16_transcoder_core_assert.svh"

	// input register
	logic        valid_s1;
	in_word_t    word_s1;

	// string state and capacity
	dec_state_t  st_q;
	dec_state_t  st_next;
	logic [15:0] cap_q;

	dec_result_t res;
	fifo_stat_t  fstat;
	logic        in_accept;
	logic        advance;
	logic        pop;
	logic [1:0]  push_count;

	// register always takes a write; writes must arrive only while idle, which the block itself does not enforce
	assign cfg_ready = 1'b1;

	// the held byte moves on when the queue has room for a full pair
	assign advance   = valid_s1 && fstat.room2;
	assign in_stall  = valid_s1 && !fstat.room2;
	assign in_accept = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// units only enter the queue when the byte is really consumed
	assign push_count = advance ? res.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
			cap_q    <= CAP_RESET;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// state steps once per consumed byte
			if (advance) begin
				st_q <= st_next;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	// byte payload, no reset
	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1 <= in_data;
		end
	end

	// decode the held byte against the string state
	utt_decode u_decode (
		.word       (word_s1),
		.state      (st_q),
		.capacity   (cap_q),
		.state_next (st_next),
		.result     (res)
	);

	// output queue doubles as the result register
	utt_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push_word0 (res.word0),
		.push_word1 (res.word1),
		.pop        (pop),
		.head_valid (out_valid),
		.head_word  (out_data),
		.stat       (fstat)
	);

	// queue never holds more than its depth
	`UTT_ASSERT_NOW(a_fifo_bound, 1'b1, fstat.level <= FIFO_FULL_LEVEL, "output queue overflow")
	// stall only while a byte is held
	`UTT_ASSERT_NOW(a_stall_held, in_stall, valid_s1, "stall without held byte")
	// a pair always starts with a high surrogate
	`UTT_ASSERT_NOW(a_pair_high, advance && (res.count == 2'd2),
		res.word0.out_unit[15:10] == HI_SURR_TAG, "pair without high surrogate")
	// once halted, only string end releases the block
	`UTT_ASSERT_NEXT(a_halt_sticky, advance && st_q.halted && !word_s1.end_of_string,
		st_q.halted, "halt dropped before string end")

endmodule

`default_nettype wire
